// ----- hdl/modbus_rtu_holding_register_slave_macros.svh -----
// Assertion macros shared by the Modbus RTU holding register slave.
`ifndef MODBUS_RTU_HOLDING_REGISTER_SLAVE_MACROS_SVH
`define MODBUS_RTU_HOLDING_REGISTER_SLAVE_MACROS_SVH
`ifndef SYNTHESIS
`define MRHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define MRHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define MRHS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define MRHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- hdl/mrhs_pkg.sv -----
// Shared types, codes and the CRC-16 byte step for the Modbus RTU slave.
package mrhs_pkg;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_HRD   = 2'd2;
    localparam logic [1:0] KIND_HWR   = 2'd3;

    localparam logic [1:0] CFG_ENABLED    = 2'd0;
    localparam logic [1:0] CFG_OWN_ADDR   = 2'd1;
    localparam logic [1:0] CFG_FRAME_GAP  = 2'd2;
    localparam logic [1:0] CFG_HOLD_COUNT = 2'd3;

    localparam logic [2:0] ERR_OK    = 3'd0;
    localparam logic [2:0] ERR_IDLE  = 3'd1;
    localparam logic [2:0] ERR_CRC   = 3'd2;
    localparam logic [2:0] ERR_OVF   = 3'd3;
    localparam logic [2:0] ERR_FUNC  = 3'd4;

    localparam logic [7:0] FC_READ     = 8'h03;
    localparam logic [7:0] FC_WSINGLE  = 8'h06;
    localparam logic [7:0] FC_WMULTI   = 8'h10;
    localparam logic [7:0] FC_EXC_FLAG = 8'h80;

    localparam logic [7:0] EXC_NONE     = 8'd0;
    localparam logic [7:0] EXC_FUNCTION = 8'd1;
    localparam logic [7:0] EXC_ADDRESS  = 8'd2;
    localparam logic [7:0] EXC_VALUE    = 8'd3;
    localparam logic [7:0] EXC_DEVICE   = 8'd4;

    localparam logic [15:0] MAX_READ_QTY  = 16'd125;
    localparam logic [15:0] MAX_WRITE_QTY = 16'd123;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    localparam int EV_RX    = 0;
    localparam int EV_CRC   = 1;
    localparam int EV_OK    = 2;
    localparam int EV_EXC   = 3;
    localparam int EV_TX    = 4;

    typedef struct packed {
        logic       init;
        logic       upd;
        logic [7:0] data;
    } t_crc_cmd;

    function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] d);
        logic [15:0] x;
        x = c ^ {8'h00, d};
        for (int b = 0; b < 8; b++) begin
            x = x[0] ? ((x >> 1) ^ CRC_POLY) : (x >> 1);
        end
        return x;
    endfunction

endpackage

// ----- hdl/modbus_rtu_holding_register_slave.sv -----
// Modbus RTU slave: frame receive, CRC check, holding register service, chunked reply.
// Byte, tick and host write go through S_CHECK to their result; host read passes S_HOST first.
// Frame close walks the buffer through the shared CRC unit, writes the words of a
// multiple-register write, then builds the reply byte by byte in chunks.
// Reset clears control state, then a clearing pass zeroes the holding store
// with input stalled; configuration writes are taken throughout.
`include "modbus_rtu_holding_register_slave_macros.svh"
module modbus_rtu_holding_register_slave #(
    parameter int MAX_FRAME = 256,
    parameter int NUM_REGS  = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [7:0]  i_rx_byte,
    input  logic [15:0] i_reg_address,
    input  logic [15:0] i_reg_value,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_tx_data,
    output logic [3:0]  o_tx_count,
    output logic        o_tx_last,
    output logic [15:0] o_host_data,
    output logic        o_host_ok,
    output logic [2:0]  o_last_error,
    output logic [31:0] o_rx_frame_count,
    output logic [31:0] o_crc_error_count,
    output logic [31:0] o_request_ok_count,
    output logic [31:0] o_exception_count,
    output logic [31:0] o_tx_frame_count
);
    localparam int FW = $clog2(MAX_FRAME);
    localparam int LW = $clog2(MAX_FRAME + 1);
    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_HOST  = 5'd2;
    localparam logic [4:0] S_CHECK = 5'd3;
    localparam logic [4:0] S_WA    = 5'd4;
    localparam logic [4:0] S_WD    = 5'd5;
    localparam logic [4:0] S_DECIDE= 5'd6;
    localparam logic [4:0] S_MWHA  = 5'd7;
    localparam logic [4:0] S_MWHD  = 5'd8;
    localparam logic [4:0] S_MWLA  = 5'd9;
    localparam logic [4:0] S_MWLD  = 5'd10;
    localparam logic [4:0] S_TINIT = 5'd11;
    localparam logic [4:0] S_THDR  = 5'd12;
    localparam logic [4:0] S_TRD   = 5'd13;
    localparam logic [4:0] S_THI   = 5'd14;
    localparam logic [4:0] S_TLO   = 5'd15;
    localparam logic [4:0] S_TCRC0 = 5'd16;
    localparam logic [4:0] S_TCRC1 = 5'd17;
    localparam logic [4:0] S_OUT   = 5'd18;

    logic [4:0]  r_state, r_ret;
    logic [AW-1:0] r_clr_addr;
    logic        r_en;
    logic [7:0]  r_own;
    logic [15:0] r_gap;
    logic [8:0]  r_hcnt;
    logic [LW-1:0] r_len, r_idx;
    logic [15:0] r_sil;
    logic [2:0]  r_err;
    logic [31:0] r_cnt [0:4];
    logic [7:0]  r_b [0:6];
    logic [7:0]  r_got_lo, r_got_hi, r_hi;
    logic [15:0] r_host_data;
    logic        r_host_ok;
    logic [63:0] r_chunk;
    logic [3:0]  r_slot;
    logic        r_tx_last, r_out_valid;
    logic [7:0]  r_hdr [0:5];
    logic [2:0]  r_hdr_n, r_pos;
    logic        r_is_read, r_send;
    logic [6:0]  r_q, r_i;
    logic [15:0] r_start;

    logic [7:0]  fb_mem [0:MAX_FRAME-1];
    logic [7:0]  r_fb_q;
    logic [15:0] st_mem [0:NUM_REGS-1];
    logic [15:0] r_st_q;

    logic          in_acc, out_acc;
    logic [16:0]   cnt;
    logic          fb_we;
    logic          st_we;
    logic [AW-1:0] st_waddr, st_raddr;
    logic [15:0]   st_wdata;
    logic [15:0]   crc;
    mrhs_pkg::t_crc_cmd crc_cmd;

    logic        e_go, e_final, e_crc;
    logic [7:0]  e_byte;
    logic [4:0]  e_next;

    logic        d_bc, d_mine, d_sup, d_rng_bad, d_close;
    logic [15:0] d_start, d_q;
    logic [7:0]  d_exc;

    assign in_acc  = i_in_valid && !o_in_stall;
    assign out_acc = r_out_valid && !i_out_stall;
    assign cnt = (17'(r_hcnt) > 17'(NUM_REGS)) ? 17'(NUM_REGS) : 17'(r_hcnt);
    assign fb_we = in_acc && (i_kind == mrhs_pkg::KIND_BYTE) && r_en
                   && (r_len < LW'(MAX_FRAME));
    assign d_close = r_en && (r_len != '0) && (r_sil >= r_gap);

    mrhs_crc u_crc (
        .i_clk (i_clk),
        .i_cmd (crc_cmd),
        .o_crc (crc)
    );

    // frame buffer
    always_ff @(posedge i_clk) begin
        if (fb_we) begin
            fb_mem[r_len[FW-1:0]] <= i_rx_byte;
        end
        r_fb_q <= fb_mem[r_idx[FW-1:0]];
    end

    // holding store
    always_ff @(posedge i_clk) begin
        if (st_we) begin
            st_mem[st_waddr] <= st_wdata;
        end
        r_st_q <= st_mem[st_raddr];
    end

    always_comb begin
        st_raddr = (r_state == S_IDLE) ? i_reg_address[AW-1:0]
                                       : AW'(r_start + 16'(r_i));
        st_we    = 1'b0;
        st_waddr = r_clr_addr;
        st_wdata = '0;
        case (r_state)
            S_CLR: begin
                st_we = 1'b1;
            end
            S_IDLE: begin
                st_we    = in_acc && (i_kind == mrhs_pkg::KIND_HWR)
                           && (17'(i_reg_address) < cnt);
                st_waddr = i_reg_address[AW-1:0];
                st_wdata = i_reg_value;
            end
            S_DECIDE: begin
                st_we    = d_mine && (r_crc_ok()) && (r_b[1] == mrhs_pkg::FC_WSINGLE)
                           && (d_exc == mrhs_pkg::EXC_NONE);
                st_waddr = d_start[AW-1:0];
                st_wdata = d_q;
            end
            S_MWLD: begin
                st_we    = 1'b1;
                st_waddr = AW'(r_start + 16'(r_i));
                st_wdata = {r_hi, r_fb_q};
            end
            default: begin
                st_we = 1'b0;
            end
        endcase
    end

    function automatic logic r_crc_ok();
        return crc == {r_got_hi, r_got_lo};
    endfunction

    // request decode
    always_comb begin
        d_bc      = (r_b[0] == 8'h00);
        d_mine    = d_bc || (r_b[0] == r_own);
        d_start   = {r_b[2], r_b[3]};
        d_q       = {r_b[4], r_b[5]};
        d_rng_bad = (17'(d_start) >= cnt) || ((17'(d_start) + 17'(d_q)) > cnt);
        d_sup     = 1'b1;
        d_exc     = mrhs_pkg::EXC_NONE;
        case (r_b[1])
            mrhs_pkg::FC_READ: begin
                if (r_len != LW'(8))                                   d_exc = mrhs_pkg::EXC_VALUE;
                else if (cnt == '0)                                    d_exc = mrhs_pkg::EXC_DEVICE;
                else if (d_q == '0 || d_q > mrhs_pkg::MAX_READ_QTY)    d_exc = mrhs_pkg::EXC_VALUE;
                else if (d_rng_bad)                                    d_exc = mrhs_pkg::EXC_ADDRESS;
            end
            mrhs_pkg::FC_WSINGLE: begin
                if (r_len != LW'(8))                                   d_exc = mrhs_pkg::EXC_VALUE;
                else if (cnt == '0)                                    d_exc = mrhs_pkg::EXC_DEVICE;
                else if (17'(d_start) >= cnt)                          d_exc = mrhs_pkg::EXC_ADDRESS;
            end
            mrhs_pkg::FC_WMULTI: begin
                if (r_len < LW'(9))                                    d_exc = mrhs_pkg::EXC_VALUE;
                else if (cnt == '0)                                    d_exc = mrhs_pkg::EXC_DEVICE;
                else if (d_q == '0 || d_q > mrhs_pkg::MAX_WRITE_QTY
                         || 16'(r_b[6]) != {d_q[14:0], 1'b0}
                         || 32'(r_len) != 32'd9 + 32'(r_b[6]))         d_exc = mrhs_pkg::EXC_VALUE;
                else if (d_rng_bad)                                    d_exc = mrhs_pkg::EXC_ADDRESS;
            end
            default: begin
                d_sup = 1'b0;
                d_exc = mrhs_pkg::EXC_FUNCTION;
            end
        endcase
    end

    // reply byte source
    always_comb begin
        e_go    = 1'b0;
        e_final = 1'b0;
        e_crc   = 1'b0;
        e_byte  = '0;
        e_next  = r_state;
        case (r_state)
            S_THDR: begin
                e_go   = 1'b1;
                e_crc  = 1'b1;
                e_byte = r_hdr[r_pos];
                if (r_pos == r_hdr_n - 3'd1) begin
                    e_next = r_is_read ? S_TRD : S_TCRC0;
                end
            end
            S_THI: begin
                e_go   = 1'b1;
                e_crc  = 1'b1;
                e_byte = r_st_q[15:8];
                e_next = S_TLO;
            end
            S_TLO: begin
                e_go   = 1'b1;
                e_crc  = 1'b1;
                e_byte = r_st_q[7:0];
                e_next = (r_i == r_q - 7'd1) ? S_TCRC0 : S_TRD;
            end
            S_TCRC0: begin
                e_go   = 1'b1;
                e_byte = crc[7:0];
                e_next = S_TCRC1;
            end
            S_TCRC1: begin
                e_go    = 1'b1;
                e_final = 1'b1;
                e_byte  = crc[15:8];
                e_next  = S_IDLE;
            end
            default: begin
                e_go = 1'b0;
            end
        endcase
    end

    always_comb begin
        crc_cmd.init = (r_state == S_CHECK) || (r_state == S_TINIT);
        crc_cmd.upd  = ((r_state == S_WD) && (r_idx < r_len - LW'(2))) || (e_go && e_crc);
        crc_cmd.data = (r_state == S_WD) ? r_fb_q : e_byte;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLR;
            r_clr_addr  <= '0;
            r_en        <= 1'b0;
            r_own       <= 8'd1;
            r_gap       <= 16'd5;
            r_hcnt      <= '0;
            r_len       <= '0;
            r_sil       <= '0;
            r_err       <= mrhs_pkg::ERR_IDLE;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 5; k++) begin
                r_cnt[k] <= '0;
            end
        end else begin
            case (r_state)
                S_CLR: begin
                    if (r_clr_addr == AW'(NUM_REGS - 1)) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_clr_addr <= r_clr_addr + AW'(1);
                    end
                end
                S_IDLE: begin
                    if (in_acc) begin
                        r_chunk     <= '0;
                        r_slot      <= '0;
                        r_tx_last   <= 1'b0;
                        r_host_data <= '0;
                        r_host_ok   <= 1'b0;
                        r_state     <= S_CHECK;
                        case (i_kind)
                            mrhs_pkg::KIND_BYTE: begin
                                if (r_en) begin
                                    if (r_len >= LW'(MAX_FRAME)) begin
                                        r_len <= '0;
                                        r_err <= mrhs_pkg::ERR_OVF;
                                    end else begin
                                        r_len <= r_len + LW'(1);
                                        r_sil <= '0;
                                    end
                                end
                            end
                            mrhs_pkg::KIND_TICK: begin
                                if (r_sil != 16'hFFFF) begin
                                    r_sil <= r_sil + 16'd1;
                                end
                            end
                            mrhs_pkg::KIND_HRD: begin
                                r_host_ok <= (17'(i_reg_address) < cnt);
                                r_state   <= S_HOST;
                            end
                            default: begin
                                r_host_ok <= (17'(i_reg_address) < cnt);
                            end
                        endcase
                    end
                end
                S_HOST: begin
                    if (r_host_ok) begin
                        r_host_data <= r_st_q;
                    end
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    r_idx <= '0;
                    if (d_close && r_len >= LW'(4)) begin
                        r_cnt[mrhs_pkg::EV_RX] <= r_cnt[mrhs_pkg::EV_RX] + 32'd1;
                        r_state <= S_WA;
                    end else begin
                        // short frame or nothing to close: single empty result
                        if (d_close) begin
                            r_len <= '0;
                        end
                        r_tx_last   <= 1'b1;
                        r_out_valid <= 1'b1;
                        r_state     <= S_OUT;
                    end
                end
                S_WA: begin
                    r_state <= S_WD;
                end
                S_WD: begin
                    if (r_idx < LW'(7)) begin
                        r_b[r_idx[2:0]] <= r_fb_q;
                    end
                    if (r_idx == r_len - LW'(2)) begin
                        r_got_lo <= r_fb_q;
                    end
                    if (r_idx == r_len - LW'(1)) begin
                        r_got_hi <= r_fb_q;
                        r_state  <= S_DECIDE;
                    end else begin
                        r_state <= S_WA;
                    end
                    r_idx <= r_idx + LW'(1);
                end
                S_DECIDE: begin
                    r_len     <= '0;
                    r_send    <= !d_bc;
                    r_is_read <= 1'b0;
                    r_i       <= '0;
                    r_q       <= d_q[6:0];
                    r_start   <= d_start;
                    r_pos     <= '0;
                    r_state   <= S_OUT;
                    r_tx_last <= 1'b1;
                    r_out_valid <= 1'b1;
                    if (!r_crc_ok()) begin
                        r_cnt[mrhs_pkg::EV_CRC] <= r_cnt[mrhs_pkg::EV_CRC] + 32'd1;
                        r_err <= mrhs_pkg::ERR_CRC;
                    end else if (d_mine) begin
                        r_err <= d_sup ? mrhs_pkg::ERR_OK : mrhs_pkg::ERR_FUNC;
                        if (d_sup) begin
                            r_cnt[mrhs_pkg::EV_OK] <= r_cnt[mrhs_pkg::EV_OK] + 32'd1;
                        end
                        // a broadcast request is done without any reply
                        if (!d_bc) begin
                            r_cnt[mrhs_pkg::EV_TX] <= r_cnt[mrhs_pkg::EV_TX] + 32'd1;
                            if (d_exc != mrhs_pkg::EXC_NONE) begin
                                r_cnt[mrhs_pkg::EV_EXC] <= r_cnt[mrhs_pkg::EV_EXC] + 32'd1;
                            end
                        end
                        r_hdr[0] <= r_own;
                        r_hdr[1] <= r_b[1];
                        r_hdr[2] <= r_b[2];
                        r_hdr[3] <= r_b[3];
                        r_hdr[4] <= r_b[4];
                        r_hdr[5] <= r_b[5];
                        r_hdr_n  <= 3'd6;
                        if (d_exc != mrhs_pkg::EXC_NONE) begin
                            r_hdr[1] <= r_b[1] | mrhs_pkg::FC_EXC_FLAG;
                            r_hdr[2] <= d_exc;
                            r_hdr_n  <= 3'd3;
                        end else if (r_b[1] == mrhs_pkg::FC_READ) begin
                            r_hdr[2]  <= {d_q[6:0], 1'b0};
                            r_hdr_n   <= 3'd3;
                            r_is_read <= 1'b1;
                        end
                        if (d_exc == mrhs_pkg::EXC_NONE && r_b[1] == mrhs_pkg::FC_WMULTI) begin
                            r_idx       <= LW'(7);
                            r_tx_last   <= 1'b0;
                            r_out_valid <= 1'b0;
                            r_state     <= S_MWHA;
                        end else if (!d_bc) begin
                            r_tx_last   <= 1'b0;
                            r_out_valid <= 1'b0;
                            r_state     <= S_TINIT;
                        end
                    end
                end
                S_MWHA: begin
                    r_state <= S_MWHD;
                end
                S_MWHD: begin
                    r_hi    <= r_fb_q;
                    r_idx   <= r_idx + LW'(1);
                    r_state <= S_MWLA;
                end
                S_MWLA: begin
                    r_state <= S_MWLD;
                end
                S_MWLD: begin
                    r_idx <= r_idx + LW'(1);
                    r_i   <= r_i + 7'd1;
                    if (r_i == r_q - 7'd1) begin
                        r_i <= '0;
                        if (r_send) begin
                            r_state <= S_TINIT;
                        end else begin
                            r_tx_last   <= 1'b1;
                            r_out_valid <= 1'b1;
                            r_state     <= S_OUT;
                        end
                    end else begin
                        r_state <= S_MWHA;
                    end
                end
                S_TINIT: begin
                    r_state <= S_THDR;
                end
                S_TRD: begin
                    r_state <= S_THI;
                end
                S_OUT: begin
                    if (out_acc) begin
                        r_out_valid <= 1'b0;
                        r_chunk     <= '0;
                        r_slot      <= '0;
                        r_state     <= r_tx_last ? S_IDLE : r_ret;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            if (e_go) begin
                r_chunk[8*r_slot[2:0] +: 8] <= e_byte;
                r_slot <= r_slot + 4'd1;
                if (r_state == S_THDR) begin
                    r_pos <= r_pos + 3'd1;
                end
                if (r_state == S_TLO) begin
                    r_i <= r_i + 7'd1;
                end
                // present a full chunk or the final partial one
                if (r_slot == 4'd7 || e_final) begin
                    r_out_valid <= 1'b1;
                    r_tx_last   <= e_final;
                    r_ret       <= e_next;
                    r_state     <= S_OUT;
                end else begin
                    r_state <= e_next;
                end
            end

            if (i_cfg_valid) begin
                case (i_cfg_index)
                    mrhs_pkg::CFG_ENABLED: begin
                        r_en  <= i_cfg_data[0];
                        r_len <= '0;
                        r_err <= i_cfg_data[0] ? mrhs_pkg::ERR_OK : mrhs_pkg::ERR_IDLE;
                    end
                    mrhs_pkg::CFG_OWN_ADDR:   r_own  <= i_cfg_data[7:0];
                    mrhs_pkg::CFG_FRAME_GAP:  r_gap  <= i_cfg_data;
                    mrhs_pkg::CFG_HOLD_COUNT: r_hcnt <= i_cfg_data[8:0];
                    default:                  r_own  <= r_own;
                endcase
            end
        end
    end

    assign o_cfg_ready        = 1'b1;
    assign o_in_stall         = (r_state != S_IDLE);
    assign o_out_valid        = r_out_valid;
    assign o_tx_data          = r_chunk;
    assign o_tx_count         = r_slot;
    assign o_tx_last          = r_tx_last;
    assign o_host_data        = r_host_data;
    assign o_host_ok          = r_host_ok;
    assign o_last_error       = r_err;
    assign o_rx_frame_count   = r_cnt[mrhs_pkg::EV_RX];
    assign o_crc_error_count  = r_cnt[mrhs_pkg::EV_CRC];
    assign o_request_ok_count = r_cnt[mrhs_pkg::EV_OK];
    assign o_exception_count  = r_cnt[mrhs_pkg::EV_EXC];
    assign o_tx_frame_count   = r_cnt[mrhs_pkg::EV_TX];

    `MRHS_ASSERT_IMPL(a_full_chunk, i_clk, i_rst_n, r_out_valid && !r_tx_last, r_slot == 4'd8)
    `MRHS_ASSERT_IMPL(a_empty_is_last, i_clk, i_rst_n, r_out_valid && r_slot == 4'd0, r_tx_last)
    `MRHS_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc, o_in_stall)
    `MRHS_ASSERT_IMPL(a_len_bound, i_clk, i_rst_n, 1'b1, r_len <= LW'(MAX_FRAME))
endmodule

// ----- hdl/mrhs_crc.sv -----
// Shared CRC-16 unit: one byte per cycle, used for frame check and reply.
module mrhs_crc (
    input  logic              i_clk,
    input  mrhs_pkg::t_crc_cmd i_cmd,
    output logic [15:0]       o_crc
);
    logic [15:0] r_crc;

    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_crc <= mrhs_pkg::CRC_INIT;
        end else if (i_cmd.upd) begin
            r_crc <= mrhs_pkg::crc_byte(r_crc, i_cmd.data);
        end
    end

    assign o_crc = r_crc;
endmodule
